// File: rtl/core/tcbt_pkg.sv
// ----------------------------------------------------------------------------
// tcbt_pkg
// Types, sizes and helper functions shared by the two-choice bucket table.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbt_pkg;

    localparam int ROW_BITS      = 8;
    localparam int MAX_HALF      = 8;
    localparam int VALUE_BITS    = 64;
    localparam int ROWS          = 1 << ROW_BITS;
    localparam int ROW_SLOTS     = 2 * MAX_HALF;
    localparam int SLOT_BITS     = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
    localparam int FREE_BITS     = $clog2(ROW_SLOTS + 1);
    localparam int HALF_BITS     = $clog2(MAX_HALF + 1);
    localparam int VADDR_BITS    = ROW_BITS + SLOT_BITS;
    localparam int VALUE_DEPTH   = ROWS * ROW_SLOTS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_SKIP  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HALF_CAP   = 2'd0,
        CFG_HARD_BOUND = 2'd1
    } t_cfg_idx;

    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [ROW_SLOTS-1:0]  t_word;
    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [FREE_BITS-1:0]  t_free;
    typedef logic [HALF_BITS-1:0]  t_half;
    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [VADDR_BITS-1:0] t_vaddr;

    typedef struct packed {
        logic        action;
        logic [7:0]  row_a;
        logic [7:0]  row_b;
        logic [63:0] value_a;
        logic [63:0] value_b;
    } t_in_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  chosen_row;
        logic [63:0] popped_value;
        logic [4:0]  free_before;
    } t_out_rsp;

    // occupancy write, one row per request
    typedef struct packed {
        logic  we;
        t_row  row;
        t_word word;
    } t_occ_wr;

    typedef struct packed {
        t_status status;
        t_row    row;
        t_free   free;
        t_slot   slot;
        logic    wr_occ;
        logic    wr_val;
        logic    rd_val;
        t_word   word;
        t_val    value;
    } t_pol_res;

    function automatic t_half eff_half(input logic [CFG_DATA_BITS-1:0] h);
        t_half c;
        if (h == '0) begin
            c = t_half'(1);
        end else if (int'(h) > MAX_HALF) begin
            c = t_half'(MAX_HALF);
        end else begin
            c = t_half'(h);
        end
        return c;
    endfunction

    function automatic t_word slot_mask(input t_half c);
        t_word m;
        for (int j = 0; j < ROW_SLOTS; j++) begin
            m[j] = (j < 2 * int'(c));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tcbt_ram.sv
// ----------------------------------------------------------------------------
// tcbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbt_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_wa,
    input  wire logic [P_WIDTH-1:0]         i_wd,
    input  wire logic                       i_re,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_ra,
    output logic      [P_WIDTH-1:0]         o_rd
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

`default_nettype wire

// File: rtl/core/tcbt_occ.sv
// ----------------------------------------------------------------------------
// tcbt_occ
// Row occupancy store: two read copies, per-row valid bits, write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbt_occ (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire tcbt_pkg::t_row   i_rd_row_a,
    input  wire tcbt_pkg::t_row   i_rd_row_b,
    input  wire tcbt_pkg::t_row   i_row_a,
    input  wire tcbt_pkg::t_row   i_row_b,
    input  wire tcbt_pkg::t_occ_wr i_wr,
    output tcbt_pkg::t_word       o_word_a,
    output tcbt_pkg::t_word       o_word_b
);
    import tcbt_pkg::*;

    t_word           ram_a;
    t_word           ram_b;
    logic [ROWS-1:0] r_row_vld;
    logic            r_byp_vld;
    t_row            r_byp_row;
    t_word           r_byp_word;

    // both copies take every write so each can serve one candidate row
    tcbt_ram #(.P_WIDTH(ROW_SLOTS), .P_DEPTH(ROWS)) u_ram_a (
        .i_clk (i_clk),
        .i_we  (i_wr.we),
        .i_wa  (i_wr.row),
        .i_wd  (i_wr.word),
        .i_re  (i_en),
        .i_ra  (i_rd_row_a),
        .o_rd  (ram_a)
    );

    tcbt_ram #(.P_WIDTH(ROW_SLOTS), .P_DEPTH(ROWS)) u_ram_b (
        .i_clk (i_clk),
        .i_we  (i_wr.we),
        .i_wa  (i_wr.row),
        .i_wd  (i_wr.word),
        .i_re  (i_en),
        .i_ra  (i_rd_row_b),
        .o_rd  (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_byp_vld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_row_vld[i_wr.row] <= 1'b1;
            end
            if (i_en) begin
                r_byp_vld <= i_wr.we;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byp_row  <= i_wr.row;
            r_byp_word <= i_wr.word;
        end
    end

    // the read data was taken on the same edge as the previous write
    always_comb begin
        if (r_byp_vld && r_byp_row == i_row_a) begin
            o_word_a = r_byp_word;
        end else begin
            o_word_a = r_row_vld[i_row_a] ? ram_a : '0;
        end
        if (r_byp_vld && r_byp_row == i_row_b) begin
            o_word_b = r_byp_word;
        end else begin
            o_word_b = r_row_vld[i_row_b] ? ram_b : '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcbt_policy.sv
// ----------------------------------------------------------------------------
// tcbt_policy
// Two-choice row selection, free-slot counts and slot search for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbt_policy (
    input  wire tcbt_pkg::t_in_req               i_req,
    input  wire tcbt_pkg::t_word                 i_word_a,
    input  wire tcbt_pkg::t_word                 i_word_b,
    input  wire logic [tcbt_pkg::CFG_DATA_BITS-1:0] i_half,
    input  wire logic                            i_hard,
    output tcbt_pkg::t_pol_res                   o_res
);
    import tcbt_pkg::*;

    t_half c;
    t_word mask;
    t_row  ra;
    t_row  rb;
    t_free fa;
    t_free fb;
    logic  is_pop;
    logic  pick_a;
    t_word word;
    t_free fr;
    t_slot free_idx;
    logic  free_hit;
    t_slot used_idx;
    logic  used_hit;

    always_comb begin
        c    = eff_half(i_half);
        mask = slot_mask(c);
        ra   = t_row'(i_req.row_a);
        rb   = t_row'(i_req.row_b);

        fa = '0;
        fb = '0;
        for (int j = 0; j < ROW_SLOTS; j++) begin
            fa = fa + t_free'(mask[j] & ~i_word_a[j]);
            fb = fb + t_free'(mask[j] & ~i_word_b[j]);
        end

        is_pop = (i_req.action == ACT_POP);
        // ties go to the lower index; equal indices land on row b
        if (is_pop) begin
            pick_a = (fa < fb) || (fa == fb && ra < rb);
        end else begin
            pick_a = (fa > fb) || (fa == fb && ra < rb);
        end
        word = pick_a ? i_word_a : i_word_b;
        fr   = pick_a ? fa : fb;

        // lowest free slot
        free_idx = '0;
        free_hit = 1'b0;
        for (int j = ROW_SLOTS - 1; j >= 0; j--) begin
            if (mask[j] && !word[j]) begin
                free_idx = t_slot'(j);
                free_hit = 1'b1;
            end
        end
        // highest used slot
        used_idx = '0;
        used_hit = 1'b0;
        for (int j = 0; j < ROW_SLOTS; j++) begin
            if (mask[j] && word[j]) begin
                used_idx = t_slot'(j);
                used_hit = 1'b1;
            end
        end

        o_res        = '0;
        o_res.status = ST_DONE;
        o_res.row    = pick_a ? ra : rb;
        o_res.free   = fr;
        o_res.value  = pick_a ? t_val'(i_req.value_a) : t_val'(i_req.value_b);
        o_res.word   = word;

        if (!is_pop) begin
            if (i_hard && fr <= t_free'(c)) begin
                o_res.status = ST_SKIP;
            end else if (free_hit) begin
                o_res.slot   = free_idx;
                o_res.wr_occ = 1'b1;
                o_res.wr_val = 1'b1;
                o_res.word   = word | (t_word'(1) << free_idx);
            end else begin
                o_res.status = ST_FULL;
            end
        end else begin
            if (used_hit) begin
                o_res.slot   = used_idx;
                o_res.wr_occ = 1'b1;
                o_res.rd_val = 1'b1;
                o_res.word   = word & ~(t_word'(1) << used_idx);
            end else begin
                o_res.status = ST_EMPTY;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/two_choice_bucket_table_top.sv
// ----------------------------------------------------------------------------
// two_choice_bucket_table_top
// Power-of-two-choices bucket table with insert and pop requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid / o_stall / i_req, result channel o_valid /
//   i_stall / o_rsp; a request or result moves on a clock edge with valid
//   high and stall low. Every request yields exactly one result, in order.
//   The occupancy read is taken on the accepting edge, policy and row update
//   follow in the policy stage, then the slot value read lands in the output
//   register. One request per cycle is sustained while i_stall stays low;
//   the occupancy write bypass lets a request use the row the previous one
//   just changed.
//   While the receiver stalls a pending result, the whole pipeline holds
//   and o_stall is raised.
//   Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index,
//   i_cfg_data; write only while no request is in flight.
//   Reset (synchronous, active low) empties every row at once through
//   per-row valid bits; no clearing pass. Capacity resets to 8, hard bound
//   to on.
// ----------------------------------------------------------------------------
`default_nettype none

module two_choice_bucket_table_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire tcbt_pkg::t_in_req                    i_req,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output tcbt_pkg::t_out_rsp                        o_rsp,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [tcbt_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [tcbt_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import tcbt_pkg::*;

    typedef struct packed {
        t_status status;
        t_row    row;
        t_free   free;
        logic    rd_val;
    } t_s2;

    logic                     en;
    logic                     acc;
    logic [CFG_DATA_BITS-1:0] r_half;
    logic                     r_hard;
    logic                     r_s1_vld;
    t_in_req                  r_s1_req;
    logic                     r_s2_vld;
    t_s2                      r_s2;
    logic                     r_o_vld;
    t_out_rsp                 r_o;
    t_word                    word_a;
    t_word                    word_b;
    t_pol_res                 pol;
    t_occ_wr                  occ_wr;
    logic                     val_we;
    t_vaddr                   val_addr;
    t_val                     val_rd;

    assign en          = !r_o_vld || !i_stall;
    assign acc         = i_valid && en;
    assign o_stall     = !en;
    assign o_valid     = r_o_vld;
    assign o_rsp       = r_o;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= CFG_DATA_BITS'(MAX_HALF);
            r_hard <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_CAP:   r_half <= i_cfg_data;
                CFG_HARD_BOUND: r_hard <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tcbt_occ u_occ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_rd_row_a (t_row'(i_req.row_a)),
        .i_rd_row_b (t_row'(i_req.row_b)),
        .i_row_a    (t_row'(r_s1_req.row_a)),
        .i_row_b    (t_row'(r_s1_req.row_b)),
        .i_wr       (occ_wr),
        .o_word_a   (word_a),
        .o_word_b   (word_b)
    );

    tcbt_policy u_policy (
        .i_req    (r_s1_req),
        .i_word_a (word_a),
        .i_word_b (word_b),
        .i_half   (r_half),
        .i_hard   (r_hard),
        .o_res    (pol)
    );

    always_comb begin
        occ_wr.we   = en && r_s1_vld && pol.wr_occ;
        occ_wr.row  = pol.row;
        occ_wr.word = pol.word;
    end

    assign val_we   = en && r_s1_vld && pol.wr_val;
    assign val_addr = {pol.row, pol.slot};

    tcbt_ram #(.P_WIDTH(VALUE_BITS), .P_DEPTH(VALUE_DEPTH)) u_val_ram (
        .i_clk (i_clk),
        .i_we  (val_we),
        .i_wa  (val_addr),
        .i_wd  (pol.value),
        .i_re  (en),
        .i_ra  (val_addr),
        .o_rd  (val_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (en) begin
            r_s1_vld <= acc;
            r_s2_vld <= r_s1_vld;
            r_o_vld  <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_req        <= i_req;
            r_s2.status     <= pol.status;
            r_s2.row        <= pol.row;
            r_s2.free       <= pol.free;
            r_s2.rd_val     <= pol.rd_val;
            r_o.status       <= r_s2.status;
            r_o.chosen_row   <= 8'(r_s2.row);
            r_o.free_before  <= 5'(r_s2.free);
            r_o.popped_value <= r_s2.rd_val ? 64'(val_rd) : 64'd0;
        end
    end

    // row updates come only from a live request in the policy stage
    a_occ_we_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_wr.we |-> (r_s1_vld && en))
        else $error("occupancy write without a live request");

    a_full_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_FULL) |-> (o_rsp.free_before == 5'd0))
        else $error("full reported with free slots left");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_EMPTY || o_rsp.status == ST_SKIP ||
         o_rsp.status == ST_FULL)) |-> (o_rsp.popped_value == 64'd0))
        else $error("value returned without a successful pop");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_s1_vld) |=> ($stable(r_s1_req) && r_s1_vld))
        else $error("policy stage moved while the pipeline was held");

endmodule

`default_nettype wire

// File: tb/two_choice_bucket_table_top_tb.sv
// ----------------------------------------------------------------------------
// two_choice_bucket_table_top_tb
// Self-checking bench for the two-choice bucket table. A short table of
// directed requests covers the policy corners (ties, equal rows, hard bound,
// full and empty rows, shrunk capacity), then random insert/pop traffic over
// a few hot rows runs under several capacity settings. Every result is checked
// against its fixed expectation if it has one, else against a bench-side copy of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_choice_bucket_table_top_tb;

    import tcbt_pkg::*;

    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 140;
    localparam int DRAIN_SLACK   = 6;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct {
        bit       is_cfg;
        t_cfg_idx cfg_idx;
        logic [CFG_DATA_BITS-1:0] cfg_data;
        t_in_req  req;
        bit       has_rsp;
        t_out_rsp rsp;
    } t_dir_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_req i_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_rsp o_rsp;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // fixed expectation that travels with the request being driven
    bit       dir_has_rsp = 1'b0;
    t_out_rsp dir_rsp = '0;

    // bench copy of the table
    logic [ROW_SLOTS-1:0] occ_q [ROWS];
    t_val                 stored_q [ROWS][ROW_SLOTS];
    logic [CFG_DATA_BITS-1:0] half_cap_q;
    logic                     hard_bound_q;

    t_out_rsp   pending_rsp_q [$];
    t_dir_entry directed_q [$];
    int         fail_cnt = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    two_choice_bucket_table_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int count_free(input t_row row, input int slots);
        int n;
        n = 0;
        for (int j = 0; j < slots; j++) begin
            if (!occ_q[row][j]) n++;
        end
        return n;
    endfunction

    // applies one insert or pop to the bench table, returns the outcome
    function automatic t_out_rsp apply_bucket_op(input t_in_req r);
        t_out_rsp o;
        int       c, slots, fa, fb, fr;
        t_row     ra, rb, row;
        logic     pick_a;
        t_val     val;
        if (half_cap_q == '0) begin
            c = 1;
        end else if (int'(half_cap_q) > MAX_HALF) begin
            c = MAX_HALF;
        end else begin
            c = int'(half_cap_q);
        end
        slots = 2 * c;
        ra = r.row_a;
        rb = r.row_b;
        fa = count_free(ra, slots);
        fb = count_free(rb, slots);
        o.popped_value = '0;
        if (r.action == ACT_INSERT) begin
            pick_a = (fa > fb) || (fa == fb && ra < rb);
            row = pick_a ? ra : rb;
            fr = pick_a ? fa : fb;
            val = pick_a ? r.value_a : r.value_b;
            if (hard_bound_q && fr <= c) begin
                o.status = ST_SKIP;
            end else begin
                o.status = ST_FULL;
                for (int j = 0; j < slots; j++) begin
                    if (!occ_q[row][j]) begin
                        occ_q[row][j] = 1'b1;
                        stored_q[row][j] = val;
                        o.status = ST_DONE;
                        break;
                    end
                end
            end
        end else begin
            pick_a = (fa < fb) || (fa == fb && ra < rb);
            row = pick_a ? ra : rb;
            fr = pick_a ? fa : fb;
            o.status = ST_EMPTY;
            for (int j = slots - 1; j >= 0; j--) begin
                if (occ_q[row][j]) begin
                    occ_q[row][j] = 1'b0;
                    o.popped_value = stored_q[row][j];
                    o.status = ST_DONE;
                    break;
                end
            end
        end
        o.chosen_row = row;
        o.free_before = 5'(fr);
        return o;
    endfunction

    // result check first, then config mirroring and bookkeeping for a newly accepted request
    always @(posedge i_clk) begin
        t_out_rsp exp_rsp;
        t_out_rsp pred_rsp;
        if (!i_rst_n) begin
            foreach (occ_q[r]) occ_q[r] = '0;
            half_cap_q = 4'd8;
            hard_bound_q = 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_rsp_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("%0t: result with nothing pending: st %0d row %0d val %h free %0d",
                                 $time, o_rsp.status, o_rsp.chosen_row, o_rsp.popped_value,
                                 o_rsp.free_before);
                end else begin
                    exp_rsp = pending_rsp_q.pop_front();
                    if (o_rsp.status !== exp_rsp.status ||
                        o_rsp.chosen_row !== exp_rsp.chosen_row ||
                        o_rsp.popped_value !== exp_rsp.popped_value ||
                        o_rsp.free_before !== exp_rsp.free_before) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT)
                            $display("%0t: mismatch st %0d/%0d row %0d/%0d val %h/%h free %0d/%0d",
                                     $time, exp_rsp.status, o_rsp.status,
                                     exp_rsp.chosen_row, o_rsp.chosen_row,
                                     exp_rsp.popped_value, o_rsp.popped_value,
                                     exp_rsp.free_before, o_rsp.free_before);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HALF_CAP:   half_cap_q = i_cfg_data;
                    CFG_HARD_BOUND: hard_bound_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                pred_rsp = apply_bucket_op(i_req);
                pending_rsp_q.push_back(dir_has_rsp ? dir_rsp : pred_rsp);
            end
        end
    end

    // receiver back-pressure in randomly chosen stall modes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= ((stall_left % 7) < 3);
            endcase
        end
    end

    task automatic add_op(input logic act, input t_row ra, input t_row rb,
                          input t_val va, input t_val vb, input bit has_rsp,
                          input t_status st = ST_DONE, input t_row row = '0,
                          input t_val pv = '0, input logic [4:0] fr = '0);
        t_dir_entry e;
        e.is_cfg = 1'b0;
        e.cfg_idx = CFG_HALF_CAP;
        e.cfg_data = '0;
        e.req.action = act;
        e.req.row_a = ra;
        e.req.row_b = rb;
        e.req.value_a = va;
        e.req.value_b = vb;
        e.has_rsp = has_rsp;
        e.rsp.status = st;
        e.rsp.chosen_row = row;
        e.rsp.popped_value = pv;
        e.rsp.free_before = fr;
        directed_q.push_back(e);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        t_dir_entry e;
        e.req = '0;
        e.has_rsp = 1'b0;
        e.rsp = '0;
        e.is_cfg = 1'b1;
        e.cfg_idx = idx;
        e.cfg_data = data;
        directed_q.push_back(e);
    endtask

    task automatic send_request(input t_in_req r, input bit has_rsp, input t_out_rsp rsp);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req <= r;
        dir_has_rsp <= has_rsp;
        dir_rsp <= rsp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // register writes only with the table idle
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        drain_pipeline();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_in_req  req;
        t_out_rsp no_rsp;
        int       hot_rows [6];
        int       insert_pct, sent, burst, gap;
        logic [CFG_DATA_BITS-1:0] half, bound_data;

        no_rsp = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table after reset, ties and equal row indices
        add_op(ACT_POP, 8'd0, 8'd0, '0, '0, 1, ST_EMPTY, 8'd0, '0, 5'd16);
        add_op(ACT_POP, 8'd255, 8'd3, '0, '0, 1, ST_EMPTY, 8'd3, '0, 5'd16);
        add_op(ACT_INSERT, 8'd5, 8'd9, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
               1, ST_DONE, 8'd5, '0, 5'd16);
        add_op(ACT_INSERT, 8'd5, 8'd9, 64'h0, 64'hA5A5_0000_FFFF_5A5A,
               1, ST_DONE, 8'd9, '0, 5'd16);
        add_op(ACT_POP, 8'd9, 8'd5, '0, '0, 1, ST_DONE, 8'd5, 64'hFFFF_FFFF_FFFF_FFFF, 5'd15);
        add_op(ACT_POP, 8'd9, 8'd5, '0, '0, 1, ST_DONE, 8'd9, 64'hA5A5_0000_FFFF_5A5A, 5'd15);
        // capacity 0 behaves as 1: hard bound, then full row
        add_cfg(CFG_HALF_CAP, 4'd0);
        add_op(ACT_INSERT, 8'd7, 8'd7, 64'h1, 64'h8000_0000_0000_0000, 0);
        add_op(ACT_INSERT, 8'd7, 8'd7, 64'h2, 64'h3, 1, ST_SKIP, 8'd7, '0, 5'd1);
        add_cfg(CFG_HARD_BOUND, 4'd0);
        add_op(ACT_INSERT, 8'd7, 8'd7, 64'h4, 64'h7FFF_FFFF_FFFF_FFFE, 0);
        add_op(ACT_INSERT, 8'd7, 8'd7, 64'h5, 64'h6, 1, ST_FULL, 8'd7, '0, 5'd0);
        // capacity above the maximum clamps
        add_cfg(CFG_HALF_CAP, 4'd15);
        add_op(ACT_INSERT, 8'd7, 8'd200, 64'h1111, 64'h2222_3333_4444_5555, 0);
        add_op(ACT_POP, 8'd7, 8'd200, '0, '0, 0);
        add_cfg(CFG_HALF_CAP, 4'd1);
        add_op(ACT_POP, 8'd7, 8'd7, '0, '0, 0);
        add_op(ACT_POP, 8'd7, 8'd7, '0, '0, 1, ST_EMPTY, 8'd7, '0, 5'd2);
        // shrunk capacity hides the upper slots but keeps them
        add_cfg(CFG_HALF_CAP, 4'd8);
        add_op(ACT_INSERT, 8'd11, 8'd11, 64'hA, 64'hDEAD_BEEF_0000_0001, 0);
        add_op(ACT_INSERT, 8'd11, 8'd11, 64'hB, 64'hDEAD_BEEF_0000_0002, 0);
        add_op(ACT_INSERT, 8'd11, 8'd11, 64'hC, 64'hDEAD_BEEF_0000_0003, 0);
        add_cfg(CFG_HALF_CAP, 4'd1);
        add_op(ACT_INSERT, 8'd11, 8'd11, 64'hD, 64'hE, 1, ST_FULL, 8'd11, '0, 5'd0);
        add_op(ACT_POP, 8'd11, 8'd11, '0, '0, 0);
        add_op(ACT_POP, 8'd11, 8'd11, '0, '0, 0);
        add_op(ACT_POP, 8'd11, 8'd11, '0, '0, 1, ST_EMPTY, 8'd11, '0, 5'd2);
        add_cfg(CFG_HALF_CAP, 4'd8);
        add_op(ACT_POP, 8'd11, 8'd11, '0, '0, 0);

        foreach (directed_q[i]) begin
            if (directed_q[i].is_cfg)
                write_reg(directed_q[i].cfg_idx, directed_q[i].cfg_data);
            else
                send_request(directed_q[i].req, directed_q[i].has_rsp, directed_q[i].rsp);
        end

        // random traffic, mostly on a handful of hot rows so they fill and drain
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0:       half = 4'd8;
                1:       half = 4'd1;
                2:       half = 4'd0;
                3:       half = 4'd15;
                4:       half = 4'd12;
                default: half = 4'($urandom_range(0, 15));
            endcase
            bound_data = 4'($urandom_range(0, 15));
            bound_data[0] = (phase < 4) ? 1'(phase % 2) : 1'($urandom_range(0, 1));
            write_reg(CFG_HALF_CAP, half);
            write_reg(CFG_HARD_BOUND, bound_data);
            insert_pct = $urandom_range(35, 85);
            foreach (hot_rows[k]) hot_rows[k] = $urandom_range(0, 255);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    req.action = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_POP;
                    req.row_a = ($urandom_range(0, 99) < 15) ? t_row'($urandom_range(0, 255))
                                                             : t_row'(hot_rows[$urandom_range(0, 5)]);
                    if ($urandom_range(0, 9) == 0)
                        req.row_b = req.row_a;
                    else if ($urandom_range(0, 99) < 15)
                        req.row_b = t_row'($urandom_range(0, 255));
                    else
                        req.row_b = t_row'(hot_rows[$urandom_range(0, 5)]);
                    req.value_a = {$urandom, $urandom};
                    req.value_b = {$urandom, $urandom};
                    send_request(req, 1'b0, no_rsp);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end

        drain_pipeline();
        if (fail_cnt == 0 && pending_rsp_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: two_choice_bucket_table_top.f
rtl/core/tcbt_pkg.sv
rtl/core/tcbt_ram.sv
rtl/core/tcbt_occ.sv
rtl/core/tcbt_policy.sv
rtl/core/two_choice_bucket_table_top.sv
tb/two_choice_bucket_table_top_tb.sv
